/* sv/mbss_pkg.sv */
// ----------------------------------------------------------------------------
// mbss_pkg: motor bridge safety supervisor shared definitions
// Request codes, register indexes, fault masks and beat payload types.
// ----------------------------------------------------------------------------
package mbss_pkg;

    typedef enum logic [3:0] {
        REQ_INIT       = 4'd0,
        REQ_SET_ENABLE = 4'd1,
        REQ_COMMAND    = 4'd2,
        REQ_DEMAND     = 4'd3,
        REQ_HALL       = 4'd4,
        REQ_LATCH      = 4'd5,
        REQ_ADC_OFF    = 4'd6,
        REQ_EVALUATE   = 4'd7,
        REQ_CLEAR      = 4'd8
    } mbss_req_e;

    typedef enum logic [3:0] {
        CFG_IS_MASTER      = 4'd0,
        CFG_LINK_TIMEOUT   = 4'd1,
        CFG_STARTUP_TIMEOUT = 4'd2,
        CFG_STALL_TIMEOUT  = 4'd3,
        CFG_CLEAR_SAFE     = 4'd4,
        CFG_ADC_LOW_DELTA  = 4'd5,
        CFG_ADC_HIGH_DELTA = 4'd6,
        CFG_ADC_MAX_SPREAD = 4'd7
    } mbss_cfg_idx_e;

    localparam int FAULT_W = 9;

    localparam logic [FAULT_W-1:0] F_WATCHDOG = 9'h001;
    localparam logic [FAULT_W-1:0] F_SHUTDOWN = 9'h002;
    localparam logic [FAULT_W-1:0] F_HALL     = 9'h004;
    localparam logic [FAULT_W-1:0] F_ADCCAL   = 9'h008;
    localparam logic [FAULT_W-1:0] F_PROTECT  = 9'h010;
    localparam logic [FAULT_W-1:0] F_CMD      = 9'h020;
    localparam logic [FAULT_W-1:0] F_LINK     = 9'h040;
    localparam logic [FAULT_W-1:0] F_STARTUP  = 9'h080;
    localparam logic [FAULT_W-1:0] F_STALL    = 9'h100;

    localparam logic [15:0] ADC_CODE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [3:0]         req_type;
        logic [31:0]        now_ms;
        logic               flag;
        logic [FAULT_W-1:0] fault_mask;
        logic [15:0]        adc_sample;
        logic               shutdown_pin_high;
        logic               hall_ok;
        logic               adc_ok;
    } mbss_req_t;

    typedef struct packed {
        logic [FAULT_W-1:0] fault_bits;
        logic               bridge_allowed;
        logic               clear_done;
        logic               calibrated;
        logic [15:0]        baseline;
    } mbss_rsp_t;

    typedef struct packed {
        logic        is_master;
        logic [15:0] link_timeout_ms;
        logic [15:0] startup_timeout_ms;
        logic [15:0] stall_timeout_ms;
        logic [15:0] clear_safe_ms;
        logic [15:0] adc_low_delta;
        logic [15:0] adc_high_delta;
        logic [15:0] adc_max_spread;
    } mbss_cfg_t;

    // calibration view: baseline established and its value
    typedef struct packed {
        logic        done;
        logic [15:0] baseline;
    } mbss_cal_t;

    // supervisor state seen by the result stage
    typedef struct packed {
        logic [FAULT_W-1:0] faults;
        logic               enabled;
        logic               demand;
        logic               clear_done;
    } mbss_stat_t;

endpackage

/* sv/mbss_if.sv */
// ----------------------------------------------------------------------------
// mbss_if: channel interfaces
// Request, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mbss_req_if
    import mbss_pkg::*;
;
    logic      valid;
    logic      ready;
    mbss_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mbss_rsp_if
    import mbss_pkg::*;
;
    logic      valid;
    logic      ready;
    mbss_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mbss_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/mbss_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mbss_cfg_regs: configuration registers
// Holds the timeout, ADC window and role settings; indexes beyond the list
// are ignored.
// ----------------------------------------------------------------------------
module mbss_cfg_regs
    import mbss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [3:0]  wr_index,
    input  logic [15:0] wr_data,
    output mbss_cfg_t   cfg
);

    mbss_cfg_t cfg_reg;
    mbss_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_IS_MASTER:       cfg_next.is_master          = wr_data[0];
                CFG_LINK_TIMEOUT:    cfg_next.link_timeout_ms    = wr_data;
                CFG_STARTUP_TIMEOUT: cfg_next.startup_timeout_ms = wr_data;
                CFG_STALL_TIMEOUT:   cfg_next.stall_timeout_ms   = wr_data;
                CFG_CLEAR_SAFE:      cfg_next.clear_safe_ms      = wr_data;
                CFG_ADC_LOW_DELTA:   cfg_next.adc_low_delta      = wr_data;
                CFG_ADC_HIGH_DELTA:  cfg_next.adc_high_delta     = wr_data;
                CFG_ADC_MAX_SPREAD:  cfg_next.adc_max_spread     = wr_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.is_master          <= 1'b0;
            cfg_reg.link_timeout_ms    <= 16'd100;
            cfg_reg.startup_timeout_ms <= 16'd500;
            cfg_reg.stall_timeout_ms   <= 16'd500;
            cfg_reg.clear_safe_ms      <= 16'd1000;
            cfg_reg.adc_low_delta      <= 16'd200;
            cfg_reg.adc_high_delta     <= 16'd200;
            cfg_reg.adc_max_spread     <= 16'd50;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/mbss_cal.sv */
// ----------------------------------------------------------------------------
// mbss_cal: bridge-off ADC calibration
// Tracks min, max, sum and count of samples; on the last sample checks the
// spread, then sets the baseline to the mean or flags a spread fault.
// ----------------------------------------------------------------------------
module mbss_cal
    import mbss_pkg::*;
#(
    parameter int CAL_SAMPLES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [3:0]  req_type,
    input  logic [15:0] adc_sample,
    input  logic [15:0] adc_max_spread,
    output mbss_cal_t   cal_cur,
    output mbss_cal_t   cal_nxt,
    output logic        spread_fault
);

    localparam int COUNT_W = $clog2(CAL_SAMPLES + 1);
    localparam int LOG_N   = $clog2(CAL_SAMPLES);
    localparam int SUM_W   = 16 + LOG_N;
    // mean by reciprocal: floor(x/N) = (x * M) >> SH, exact for x < 2^SUM_W
    localparam int SH      = SUM_W + LOG_N;
    localparam int RECIP_W = SUM_W + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SH) + longint'(CAL_SAMPLES) - 64'd1) / longint'(CAL_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(CAL_SAMPLES);

    logic [15:0]        min_reg, min_next;
    logic [15:0]        max_reg, max_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               done_reg, done_next;
    logic [15:0]        base_reg, base_next;

    logic [15:0]          smp_min, smp_max;
    logic [SUM_W-1:0]     smp_sum;
    logic [COUNT_W-1:0]   smp_count;
    logic [SUM_W+RECIP_W-1:0] mean_prod;
    logic                 take, last, too_wide;

    always_comb
    begin
        take      = step && (req_type == REQ_ADC_OFF) && !done_reg && (count_reg < COUNT_FULL);
        smp_min   = (adc_sample < min_reg) ? adc_sample : min_reg;
        smp_max   = (adc_sample > max_reg) ? adc_sample : max_reg;
        smp_sum   = sum_reg + SUM_W'(adc_sample);
        smp_count = count_reg + COUNT_W'(1);
        last      = (smp_count == COUNT_FULL);
        too_wide  = (smp_max - smp_min) > adc_max_spread;
        mean_prod = (SUM_W + RECIP_W)'(smp_sum) * (SUM_W + RECIP_W)'(RECIP);

        min_next     = min_reg;
        max_next     = max_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        done_next    = done_reg;
        base_next    = base_reg;
        spread_fault = 1'b0;

        if (step && (req_type == REQ_INIT))
        begin
            min_next   = ADC_CODE_MAX;
            max_next   = '0;
            sum_next   = '0;
            count_next = '0;
            done_next  = 1'b0;
            base_next  = '0;
        end
        else if (take)
        begin
            min_next   = smp_min;
            max_next   = smp_max;
            sum_next   = smp_sum;
            count_next = smp_count;
            if (last)
            begin
                if (too_wide)
                begin
                    spread_fault = 1'b1;
                end
                else
                begin
                    done_next = 1'b1;
                    base_next = mean_prod[SH +: 16];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= ADC_CODE_MAX;
            max_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            base_reg  <= '0;
        end
        else
        begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            base_reg  <= base_next;
        end
    end

    assign cal_cur.done     = done_reg;
    assign cal_cur.baseline = base_reg;
    assign cal_nxt.done     = done_next;
    assign cal_nxt.baseline = base_next;

endmodule

/* sv/mbss_core.sv */
// ----------------------------------------------------------------------------
// mbss_core: fault supervisor state
// Enable/demand state, event timestamps and latched faults; evaluate and
// clear checks.
// ----------------------------------------------------------------------------
module mbss_core
    import mbss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  mbss_req_t  req,
    input  mbss_cfg_t  cfg,
    input  mbss_cal_t  cal_cur,
    input  logic       spread_fault,
    output mbss_stat_t stat_nxt
);

    logic               enabled_reg, enabled_next;
    logic               demand_reg, demand_next;
    logic               hall_edge_seen_reg, hall_edge_seen_next;
    logic [FAULT_W-1:0] faults_reg, faults_next;
    logic [31:0]        cmd_time_reg, cmd_time_next;
    logic [31:0]        hall_time_reg, hall_time_next;
    logic [31:0]        start_time_reg, start_time_next;
    logic [31:0]        off_time_reg, off_time_next;

    logic        adc_in_window;
    logic        link_late, startup_late, stall_late, off_long;
    logic        clear_ok, clear_done;
    logic [31:0] link_age, startup_age, stall_age, off_age;

    always_comb
    begin
        // window is [baseline - low, baseline + high], no wrap
        adc_in_window = (({1'b0, req.adc_sample} + {1'b0, cfg.adc_low_delta})
                            >= {1'b0, cal_cur.baseline})
                     && ({1'b0, req.adc_sample}
                            <= ({1'b0, cal_cur.baseline} + {1'b0, cfg.adc_high_delta}));

        link_age     = req.now_ms - cmd_time_reg;
        startup_age  = req.now_ms - start_time_reg;
        stall_age    = req.now_ms - hall_time_reg;
        off_age      = req.now_ms - off_time_reg;
        link_late    = link_age    > {16'd0, cfg.link_timeout_ms};
        startup_late = startup_age > {16'd0, cfg.startup_timeout_ms};
        stall_late   = stall_age   > {16'd0, cfg.stall_timeout_ms};
        off_long     = off_age    >= {16'd0, cfg.clear_safe_ms};

        clear_ok = !enabled_reg && !demand_reg && req.shutdown_pin_high
                && req.adc_ok && req.hall_ok && cal_cur.done && adc_in_window
                && ((faults_reg & (F_WATCHDOG | F_SHUTDOWN)) == '0) && off_long;

        enabled_next        = enabled_reg;
        demand_next         = demand_reg;
        hall_edge_seen_next = hall_edge_seen_reg;
        faults_next         = faults_reg;
        cmd_time_next       = cmd_time_reg;
        hall_time_next      = hall_time_reg;
        start_time_next     = start_time_reg;
        off_time_next       = off_time_reg;
        clear_done          = 1'b0;

        if (step)
        begin
            case (req.req_type)
                REQ_INIT:
                begin
                    enabled_next        = 1'b0;
                    demand_next         = 1'b0;
                    hall_edge_seen_next = 1'b0;
                    faults_next         = req.flag ? F_WATCHDOG : '0;
                    cmd_time_next       = req.now_ms;
                    hall_time_next      = req.now_ms;
                    start_time_next     = req.now_ms;
                    off_time_next       = req.now_ms;
                end
                REQ_SET_ENABLE:
                begin
                    enabled_next = req.flag;
                    if (!req.flag)
                    begin
                        demand_next = 1'b0;
                    end
                end
                REQ_COMMAND:
                begin
                    cmd_time_next = req.now_ms;
                end
                REQ_DEMAND:
                begin
                    if (req.flag && !demand_reg)
                    begin
                        start_time_next     = req.now_ms;
                        hall_edge_seen_next = 1'b0;
                    end
                    if (!req.flag && demand_reg)
                    begin
                        off_time_next = req.now_ms;
                    end
                    demand_next = req.flag;
                end
                REQ_HALL:
                begin
                    hall_time_next      = req.now_ms;
                    hall_edge_seen_next = 1'b1;
                end
                REQ_LATCH:
                begin
                    faults_next = faults_reg | req.fault_mask;
                end
                REQ_ADC_OFF:
                begin
                    if (spread_fault)
                    begin
                        faults_next = faults_reg | F_ADCCAL;
                    end
                end
                REQ_EVALUATE:
                begin
                    if (!req.shutdown_pin_high)
                    begin
                        faults_next = faults_next | F_SHUTDOWN;
                    end
                    if (!req.hall_ok)
                    begin
                        faults_next = faults_next | F_HALL;
                    end
                    if (!req.adc_ok)
                    begin
                        faults_next = faults_next | F_ADCCAL;
                    end
                    else if (cal_cur.done && !adc_in_window)
                    begin
                        faults_next = faults_next | F_PROTECT;
                    end
                    if (enabled_reg && demand_reg)
                    begin
                        if (link_late)
                        begin
                            faults_next = faults_next | (cfg.is_master ? F_CMD : F_LINK);
                        end
                        if (!hall_edge_seen_reg && startup_late)
                        begin
                            faults_next = faults_next | F_STARTUP;
                        end
                        if (hall_edge_seen_reg && stall_late)
                        begin
                            faults_next = faults_next | F_STALL;
                        end
                    end
                end
                REQ_CLEAR:
                begin
                    if (clear_ok)
                    begin
                        faults_next  = '0;
                        enabled_next = 1'b0;
                        clear_done   = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg        <= 1'b0;
            demand_reg         <= 1'b0;
            hall_edge_seen_reg <= 1'b0;
            faults_reg         <= '0;
            cmd_time_reg       <= '0;
            hall_time_reg      <= '0;
            start_time_reg     <= '0;
            off_time_reg       <= '0;
        end
        else
        begin
            enabled_reg        <= enabled_next;
            demand_reg         <= demand_next;
            hall_edge_seen_reg <= hall_edge_seen_next;
            faults_reg         <= faults_next;
            cmd_time_reg       <= cmd_time_next;
            hall_time_reg      <= hall_time_next;
            start_time_reg     <= start_time_next;
            off_time_reg       <= off_time_next;
        end
    end

    assign stat_nxt.faults     = faults_next;
    assign stat_nxt.enabled    = enabled_next;
    assign stat_nxt.demand     = demand_next;
    assign stat_nxt.clear_done = clear_done;

endmodule

/* sv/motor_bridge_safety_supervisor.sv */
// ----------------------------------------------------------------------------
// motor_bridge_safety_supervisor: motor bridge safety supervisor top level
// Input beat register, combinational state update, result beat register.
// ----------------------------------------------------------------------------
// Each request beat (init, enable, command, demand, hall, latch, bridge-off
// ADC sample, evaluate, clear) yields exactly one result beat carrying the
// latched faults, bridge-allowed, calibrated, baseline and clear_done, all
// as they stand after the event. Throughput is one beat per cycle while
// rsp.ready is high. An accepted request loads the input register; the
// state update and the result register, which raises result valid, load
// from it once the result register is free or draining. The result
// register keeps taking beats as long as rsp.ready is high; when it is
// low, one more request is held in the input register before req.ready
// drops. Register writes on cfg are always taken (cfg.ready tied high)
// and must only be done while no request is in flight. Timeouts use
// wrapping 32-bit ms time.
// ----------------------------------------------------------------------------
module motor_bridge_safety_supervisor
    import mbss_pkg::*;
#(
    parameter int CAL_SAMPLES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    mbss_req_if.sink   req,
    mbss_rsp_if.source rsp,
    mbss_cfg_if.sink   cfg
);

    // input register
    logic      req_valid_reg;
    mbss_req_t req_reg;
    // result register
    logic      rsp_valid_reg;
    mbss_rsp_t rsp_reg;

    logic       advance;   // result register free or draining this cycle
    logic       step;      // a held request updates state now
    mbss_cfg_t  cfg_q;
    mbss_cal_t  cal_cur;
    mbss_cal_t  cal_nxt;
    logic       spread_fault;
    mbss_stat_t stat_nxt;

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign step      = req_valid_reg && advance;
    assign req.ready = !req_valid_reg || advance;
    assign cfg.ready = 1'b1;

    mbss_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    // calibration samples and baseline
    mbss_cal #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_cal (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .req_type       (req_reg.req_type),
        .adc_sample     (req_reg.adc_sample),
        .adc_max_spread (cfg_q.adc_max_spread),
        .cal_cur        (cal_cur),
        .cal_nxt        (cal_nxt),
        .spread_fault   (spread_fault)
    );

    // faults, timeouts, enable/demand
    mbss_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .req          (req_reg),
        .cfg          (cfg_q),
        .cal_cur      (cal_cur),
        .spread_fault (spread_fault),
        .stat_nxt     (stat_nxt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                req_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg <= req.data;
        end
        if (step)
        begin
            rsp_reg.fault_bits     <= stat_nxt.faults;
            rsp_reg.bridge_allowed <= stat_nxt.enabled && stat_nxt.demand
                                      && cal_nxt.done && (stat_nxt.faults == '0);
            rsp_reg.clear_done     <= stat_nxt.clear_done;
            rsp_reg.calibrated     <= cal_nxt.done;
            rsp_reg.baseline       <= cal_nxt.baseline;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

endmodule

/* sv/mbss_checker.sv */
// ----------------------------------------------------------------------------
// mbss_checker: port-level checks for the supervisor
// Result beat consistency and output hold under backpressure.
// ----------------------------------------------------------------------------
module mbss_checker
    import mbss_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [FAULT_W-1:0] fault_bits,
    input logic               bridge_allowed,
    input logic               clear_done,
    input logic               calibrated,
    input logic [15:0]        baseline
);

    // a stalled result beat stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped while stalled");

    // a successful clear leaves no latched fault
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && clear_done |-> fault_bits == '0)
        else $error("clear_done with faults still latched");

    // bridge allowed only when calibrated and fault free
    a_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && bridge_allowed |-> calibrated && fault_bits == '0)
        else $error("bridge allowed with fault or without calibration");

    // baseline reads zero until calibration completes
    a_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !calibrated |-> baseline == 16'd0)
        else $error("baseline nonzero while not calibrated");

endmodule

bind motor_bridge_safety_supervisor mbss_checker u_mbss_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .fault_bits     (rsp.data.fault_bits),
    .bridge_allowed (rsp.data.bridge_allowed),
    .clear_done     (rsp.data.clear_done),
    .calibrated     (rsp.data.calibrated),
    .baseline       (rsp.data.baseline)
);

/* tb/mbss_checker.sv */
// ----------------------------------------------------------------------------
// mbss_result_checker: result checker for the motor bridge safety supervisor
// Watches the request, result and register channels. It keeps its own copy
// of the supervisor state and registers, computes the status that each
// accepted request beat must produce, and compares it field by field with
// the result beats in order.
// ----------------------------------------------------------------------------
module mbss_result_checker
    import mbss_pkg::*;
#(
    parameter int CAL_SAMPLES = 16
)
(
    input  logic clk,
    input  logic rst_n,
    mbss_req_if  req,
    mbss_rsp_if  rsp,
    mbss_cfg_if  cfg,
    output int   errors,
    output int   outstanding,
    output int   beats_checked,
    output int   clears_seen,
    output int   allowed_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    mbss_cfg_t          cfg_q;
    logic               enabled;
    logic               demand;
    logic               hall_edge_seen;
    logic               cal_ok;
    logic [FAULT_W-1:0] faults;
    logic [31:0]        t_command;
    logic [31:0]        t_hall;
    logic [31:0]        t_motion;
    logic [31:0]        t_bridge_off;
    logic [15:0]        cal_min;
    logic [15:0]        cal_max;
    logic [31:0]        cal_sum;
    int                 cal_cnt;
    logic [15:0]        cal_base;

    mbss_rsp_t          pending_status[$];
    int                 mismatches;
    int                 n_checked;
    int                 n_cleared;
    int                 n_allowed;

    function automatic mbss_cfg_t default_settings();
        return '{is_master: 1'b0, link_timeout_ms: 16'd100,
                 startup_timeout_ms: 16'd500, stall_timeout_ms: 16'd500,
                 clear_safe_ms: 16'd1000, adc_low_delta: 16'd200,
                 adc_high_delta: 16'd200, adc_max_spread: 16'd50};
    endfunction

    function automatic void clear_supervisor(logic [31:0] t);
        enabled        = 1'b0;
        demand         = 1'b0;
        hall_edge_seen = 1'b0;
        cal_ok         = 1'b0;
        faults         = '0;
        t_command      = t;
        t_hall         = t;
        t_motion       = t;
        t_bridge_off   = t;
        cal_min        = ADC_CODE_MAX;
        cal_max        = '0;
        cal_sum        = '0;
        cal_cnt        = 0;
        cal_base       = '0;
    endfunction

    // wrapping ms difference strictly above the limit
    function automatic logic elapsed_over(logic [31:0] now, logic [31:0] then,
                                          logic [15:0] limit);
        logic [31:0] span;
        span = now - then;
        return span > {16'd0, limit};
    endfunction

    // window around the baseline, no wrap at either end
    function automatic logic in_window(logic [15:0] adc);
        int v;
        int lo;
        int hi;
        v  = int'(adc);
        lo = int'(cal_base);
        hi = int'(cal_base);
        lo = lo - int'(cfg_q.adc_low_delta);
        hi = hi + int'(cfg_q.adc_high_delta);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic void write_setting(logic [3:0] idx, logic [15:0] val);
        case (idx)
            CFG_IS_MASTER:       cfg_q.is_master          = val[0];
            CFG_LINK_TIMEOUT:    cfg_q.link_timeout_ms    = val;
            CFG_STARTUP_TIMEOUT: cfg_q.startup_timeout_ms = val;
            CFG_STALL_TIMEOUT:   cfg_q.stall_timeout_ms   = val;
            CFG_CLEAR_SAFE:      cfg_q.clear_safe_ms      = val;
            CFG_ADC_LOW_DELTA:   cfg_q.adc_low_delta      = val;
            CFG_ADC_HIGH_DELTA:  cfg_q.adc_high_delta     = val;
            CFG_ADC_MAX_SPREAD:  cfg_q.adc_max_spread     = val;
            default: ;
        endcase
    endfunction

    // applies one event to the state copy and returns the status after it
    function automatic mbss_rsp_t supervise_event(mbss_req_t ev);
        mbss_rsp_t   st;
        logic        granted;
        logic [15:0] spread;
        logic [31:0] off_span;
        granted = 1'b0;
        case (ev.req_type)
            REQ_INIT:
            begin
                clear_supervisor(ev.now_ms);
                if (ev.flag)
                    faults = F_WATCHDOG;
            end
            REQ_SET_ENABLE:
            begin
                enabled = ev.flag;
                if (!ev.flag)
                    demand = 1'b0;
            end
            REQ_COMMAND:
                t_command = ev.now_ms;
            REQ_DEMAND:
            begin
                if (ev.flag && !demand)
                begin
                    t_motion       = ev.now_ms;
                    hall_edge_seen = 1'b0;
                end
                if (!ev.flag && demand)
                    t_bridge_off = ev.now_ms;
                demand = ev.flag;
            end
            REQ_HALL:
            begin
                t_hall         = ev.now_ms;
                hall_edge_seen = 1'b1;
            end
            REQ_LATCH:
                faults = faults | ev.fault_mask;
            REQ_ADC_OFF:
            begin
                if (!cal_ok && cal_cnt < CAL_SAMPLES)
                begin
                    if (ev.adc_sample < cal_min)
                        cal_min = ev.adc_sample;
                    if (ev.adc_sample > cal_max)
                        cal_max = ev.adc_sample;
                    cal_sum = cal_sum + 32'(ev.adc_sample);
                    cal_cnt++;
                    if (cal_cnt == CAL_SAMPLES)
                    begin
                        spread = cal_max - cal_min;
                        if (spread > cfg_q.adc_max_spread)
                            faults = faults | F_ADCCAL;
                        else
                        begin
                            cal_base = 16'(cal_sum / CAL_SAMPLES);
                            cal_ok   = 1'b1;
                        end
                    end
                end
            end
            REQ_EVALUATE:
            begin
                if (!ev.shutdown_pin_high)
                    faults = faults | F_SHUTDOWN;
                if (!ev.hall_ok)
                    faults = faults | F_HALL;
                if (!ev.adc_ok)
                    faults = faults | F_ADCCAL;
                else if (cal_ok && !in_window(ev.adc_sample))
                    faults = faults | F_PROTECT;
                if (enabled && demand)
                begin
                    if (elapsed_over(ev.now_ms, t_command, cfg_q.link_timeout_ms))
                        faults = faults | (cfg_q.is_master ? F_CMD : F_LINK);
                    if (!hall_edge_seen &&
                        elapsed_over(ev.now_ms, t_motion, cfg_q.startup_timeout_ms))
                        faults = faults | F_STARTUP;
                    if (hall_edge_seen &&
                        elapsed_over(ev.now_ms, t_hall, cfg_q.stall_timeout_ms))
                        faults = faults | F_STALL;
                end
            end
            REQ_CLEAR:
            begin
                off_span = ev.now_ms - t_bridge_off;
                if (!enabled && !demand && ev.shutdown_pin_high && ev.adc_ok &&
                    ev.hall_ok && cal_ok && in_window(ev.adc_sample) &&
                    (faults & (F_WATCHDOG | F_SHUTDOWN)) == '0 &&
                    off_span >= {16'd0, cfg_q.clear_safe_ms})
                begin
                    faults  = '0;
                    enabled = 1'b0;
                    granted = 1'b1;
                end
            end
            default: ;
        endcase
        st.fault_bits     = faults;
        st.bridge_allowed = enabled && demand && cal_ok && (faults == '0);
        st.clear_done     = granted;
        st.calibrated     = cal_ok;
        st.baseline       = cal_base;
        return st;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        mbss_rsp_t got;
        mbss_rsp_t want;
        if (!rst_n)
        begin
            cfg_q = default_settings();
            clear_supervisor(32'd0);
            pending_status.delete();
            mismatches = 0;
            n_checked  = 0;
            n_cleared  = 0;
            n_allowed  = 0;
        end
        else
        begin
            // result first: it belongs to an older request than any taken now
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.data;
                if (pending_status.size() == 0)
                begin
                    $display("%0t ns: result beat with nothing expected, actual %0h",
                             $time, got);
                    mismatches++;
                end
                else
                begin
                    want = pending_status.pop_front();
                    check_field("fault_bits", 16'(want.fault_bits), 16'(got.fault_bits));
                    check_field("bridge_allowed", 16'(want.bridge_allowed),
                                16'(got.bridge_allowed));
                    check_field("clear_done", 16'(want.clear_done), 16'(got.clear_done));
                    check_field("calibrated", 16'(want.calibrated), 16'(got.calibrated));
                    check_field("baseline", want.baseline, got.baseline);
                    n_checked++;
                    if (want.clear_done)
                        n_cleared++;
                    if (want.bridge_allowed)
                        n_allowed++;
                end
            end
            if (cfg.valid && cfg.ready)
                write_setting(cfg.index, cfg.data);
            if (req.valid && req.ready)
                pending_status.push_back(supervise_event(req.data));
        end
        errors        <= mismatches;
        outstanding   <= pending_status.size();
        beats_checked <= n_checked;
        clears_seen   <= n_cleared;
        allowed_seen  <= n_allowed;
    end

endmodule

/* tb/motor_bridge_safety_supervisor_tb.sv */
// ----------------------------------------------------------------------------
// motor_bridge_safety_supervisor_tb: top of the supervisor testbench
// Drives request beats and register writes, stalls the result side, and
// gives the verdict from the checker's error and outstanding counts. A
// short directed run hits the boundary cases under the defaults, then six
// register settings (defaults in master role, all zero, all ones, random)
// each get a burst of random supervision sessions mixed with noise beats.
// ----------------------------------------------------------------------------
module motor_bridge_safety_supervisor_tb;
    import mbss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CAL_SAMPLES    = 16;
    localparam int         PHASE_ITEMS    = 270;
    localparam logic [3:0] REQ_UNUSED_TOP = 4'hF;   // highest undefined code

    localparam mbss_cfg_t DEFAULT_SETTINGS = '{
        is_master: 1'b0, link_timeout_ms: 16'd100, startup_timeout_ms: 16'd500,
        stall_timeout_ms: 16'd500, clear_safe_ms: 16'd1000,
        adc_low_delta: 16'd200, adc_high_delta: 16'd200, adc_max_spread: 16'd50};

    logic clk;
    logic rst_n;

    mbss_req_if req_if ();
    mbss_rsp_if rsp_if ();
    mbss_cfg_if cfg_if ();

    int errors;
    int outstanding;
    int beats_checked;
    int clears_seen;
    int allowed_seen;

    // stimulus bookkeeping
    mbss_cfg_t   cur;            // settings last written
    logic        idle_on;        // random gaps on both sides
    int          sent;
    int          settings_used;
    logic [31:0] clock_ms;       // running timestamp of the sessions
    logic [31:0] t_cmd;          // times of the last events sent, for edge hits
    logic [31:0] t_hall;
    logic [31:0] t_motion;
    logic [31:0] t_off;
    logic [15:0] base_guess;     // mean of the last calibration samples sent

    motor_bridge_safety_supervisor #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    mbss_result_checker #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_if),
        .rsp           (rsp_if),
        .cfg           (cfg_if),
        .errors        (errors),
        .outstanding   (outstanding),
        .beats_checked (beats_checked),
        .clears_seen   (clears_seen),
        .allowed_seen  (allowed_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // result side: ready high, with random stall bursts while idling is on
    initial
    begin
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic odds(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // small steps mostly, scaled to the current timeouts, with rare huge jumps
    function automatic logic [31:0] advance(logic [31:0] t);
        int unsigned scale;
        int unsigned r;
        scale = {16'd0, cur.link_timeout_ms};
        if (cur.startup_timeout_ms > scale)
            scale = {16'd0, cur.startup_timeout_ms};
        if (cur.stall_timeout_ms > scale)
            scale = {16'd0, cur.stall_timeout_ms};
        if (cur.clear_safe_ms > scale)
            scale = {16'd0, cur.clear_safe_ms};
        if (scale < 8)
            scale = 8;
        r = $urandom_range(0, 99);
        if (r < 60)
            return t + $urandom_range(0, scale / 8);
        if (r < 90)
            return t + $urandom_range(0, scale);
        if (r < 97)
            return t + $urandom_range(0, scale * 3);
        return t + $urandom;
    endfunction

    // one of the limits hit on the nose, one below or one above
    function automatic logic [31:0] at_edge(logic [31:0] base, logic [15:0] limit);
        int nudge;
        nudge = $urandom_range(0, 2);
        nudge = nudge - 1;
        return base + {16'd0, limit} + 32'(nudge);
    endfunction

    // ADC reading around the baseline window, edges included
    function automatic logic [15:0] near_base();
        int v;
        int r;
        r = $urandom_range(0, 9);
        v = int'(base_guess);
        if (r < 2)
            v = $urandom_range(0, 65535);
        else if (r == 2)
            v = v - int'(cur.adc_low_delta) - int'($urandom_range(0, 1));
        else if (r == 3)
            v = v + int'(cur.adc_high_delta) + int'($urandom_range(0, 1));
        else
            v = v - int'(cur.adc_low_delta)
                + int'($urandom_range(0, int'(cur.adc_low_delta) + cur.adc_high_delta));
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    function automatic mbss_req_t beat_of(mbss_req_e kind, logic [31:0] t);
        mbss_req_t b;
        b.req_type          = kind;
        b.now_ms            = t;
        b.flag              = 1'b0;
        b.fault_mask        = '0;
        b.adc_sample        = base_guess;
        b.shutdown_pin_high = 1'b1;
        b.hall_ok           = 1'b1;
        b.adc_ok            = 1'b1;
        return b;
    endfunction

    function automatic mbss_cfg_t random_settings();
        mbss_cfg_t s;
        s.is_master          = 1'($urandom_range(0, 1));
        s.link_timeout_ms    = 16'($urandom_range(0, 2000));
        s.startup_timeout_ms = 16'($urandom_range(0, 2000));
        s.stall_timeout_ms   = 16'($urandom_range(0, 2000));
        s.clear_safe_ms      = 16'($urandom_range(0, 3000));
        s.adc_low_delta      = odds(50) ? 16'($urandom_range(0, 500))
                                        : 16'($urandom_range(0, 65535));
        s.adc_high_delta     = odds(50) ? 16'($urandom_range(0, 500))
                                        : 16'($urandom_range(0, 65535));
        s.adc_max_spread     = odds(60) ? 16'($urandom_range(0, 200))
                                        : 16'($urandom_range(0, 65535));
        return s;
    endfunction

    // hold valid until the beat is taken, then maybe leave a gap
    task automatic send_beat(mbss_req_t b);
        req_if.valid <= 1'b1;
        req_if.data  <= b;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        sent++;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // wait for every expected result, then let the pipeline drain
    task automatic wait_idle();
        int spins;
        spins = 0;
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 && spins < 5000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(mbss_cfg_idx_e idx, logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
    endtask

    task automatic apply_settings(mbss_cfg_t s);
        wait_idle();
        put_reg(CFG_IS_MASTER, {15'd0, s.is_master});
        put_reg(CFG_LINK_TIMEOUT, s.link_timeout_ms);
        put_reg(CFG_STARTUP_TIMEOUT, s.startup_timeout_ms);
        put_reg(CFG_STALL_TIMEOUT, s.stall_timeout_ms);
        put_reg(CFG_CLEAR_SAFE, s.clear_safe_ms);
        put_reg(CFG_ADC_LOW_DELTA, s.adc_low_delta);
        put_reg(CFG_ADC_HIGH_DELTA, s.adc_high_delta);
        put_reg(CFG_ADC_MAX_SPREAD, s.adc_max_spread);
        cfg_if.valid <= 1'b0;
        cur = s;
        settings_used++;
    endtask

    // directed edges, run under the default settings
    task automatic run_directed();
        mbss_req_t b;
        // undefined code with every field at its top, straight out of reset
        b          = '1;
        b.req_type = REQ_UNUSED_TOP;
        send_beat(b);
        // init with watchdog reset, then a clear that must be refused
        b      = beat_of(REQ_INIT, 32'd0);
        b.flag = 1'b1;
        send_beat(b);
        send_beat(beat_of(REQ_CLEAR, 32'd5000));
        send_beat(beat_of(REQ_INIT, 32'd100));
        // spread exactly at the limit still calibrates, mean 1025
        for (int i = 0; i < CAL_SAMPLES; i++)
        begin
            b            = beat_of(REQ_ADC_OFF, 32'd100);
            b.adc_sample = (i % 2 != 0) ? 16'd1050 : 16'd1000;
            send_beat(b);
        end
        // a sample after the count is full is ignored
        b            = beat_of(REQ_ADC_OFF, 32'd100);
        b.adc_sample = 16'd0;
        send_beat(b);
        base_guess   = 16'd1025;
        // lower window edge, inside
        b            = beat_of(REQ_EVALUATE, 32'd100);
        b.adc_sample = 16'd825;
        send_beat(b);
        b      = beat_of(REQ_SET_ENABLE, 32'd150);
        b.flag = 1'b1;
        send_beat(b);
        b      = beat_of(REQ_DEMAND, 32'd200);
        b.flag = 1'b1;
        send_beat(b);
        send_beat(beat_of(REQ_COMMAND, 32'd250));
        // link exactly at its limit, upper window edge: bridge allowed
        b            = beat_of(REQ_EVALUATE, 32'd350);
        b.adc_sample = 16'd1225;
        send_beat(b);
        send_beat(beat_of(REQ_HALL, 32'd400));
        // stall at its limit, link over, one count above the window
        b            = beat_of(REQ_EVALUATE, 32'd900);
        b.adc_sample = 16'd1226;
        send_beat(b);
        // disabling drops demand without moving the bridge-off time
        send_beat(beat_of(REQ_SET_ENABLE, 32'd950));
        // off for one ms short of the safe time, then exactly the safe time
        send_beat(beat_of(REQ_CLEAR, 32'd1099));
        send_beat(beat_of(REQ_CLEAR, 32'd1100));
        b            = beat_of(REQ_LATCH, 32'd1200);
        b.fault_mask = '1;
        send_beat(b);
    endtask

    task automatic noise_burst();
        mbss_req_t b;
        int        n;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            b.req_type          = 4'($urandom_range(0, 15));
            b.now_ms            = odds(50) ? advance(clock_ms) : $urandom;
            b.flag              = 1'($urandom_range(0, 1));
            b.fault_mask        = 9'($urandom_range(0, 511));
            b.adc_sample        = 16'($urandom_range(0, 65535));
            b.shutdown_pin_high = 1'($urandom_range(0, 1));
            b.hall_ok           = 1'($urandom_range(0, 1));
            b.adc_ok            = 1'($urandom_range(0, 1));
            send_beat(b);
        end
    endtask

    // init, calibrate, run the bridge for a while, shut down, try to clear
    task automatic run_session();
        mbss_req_t   b;
        int          n;
        int          sp;
        int          lo_v;
        int          v;
        int          r;
        logic        wide;
        logic [31:0] sum;
        clock_ms = advance(clock_ms);
        b        = beat_of(REQ_INIT, clock_ms);
        b.flag   = odds(10);
        send_beat(b);
        t_cmd    = clock_ms;
        t_hall   = clock_ms;
        t_motion = clock_ms;
        t_off    = clock_ms;

        // calibration, sometimes too wide, sometimes with extra samples
        lo_v = int'($urandom_range(0, 65535));
        sp   = int'(cur.adc_max_spread);
        if (lo_v + sp > 65535)
            sp = 65535 - lo_v;
        wide = odds(20);
        sum  = '0;
        n    = CAL_SAMPLES + (odds(25) ? int'($urandom_range(1, 3)) : 0);
        for (int i = 0; i < n; i++)
        begin
            v = wide ? int'($urandom_range(0, 65535)) : lo_v + int'($urandom_range(0, sp));
            if (i < CAL_SAMPLES)
                sum = sum + 32'(v);
            clock_ms     = clock_ms + $urandom_range(0, 3);
            b            = beat_of(REQ_ADC_OFF, clock_ms);
            b.adc_sample = 16'(v);
            send_beat(b);
        end
        base_guess = 16'(sum / CAL_SAMPLES);
        if (odds(12))
        begin
            b            = beat_of(REQ_LATCH, clock_ms);
            b.fault_mask = 9'($urandom_range(1, 511));
            send_beat(b);
        end

        // motion
        clock_ms = advance(clock_ms);
        b        = beat_of(REQ_SET_ENABLE, clock_ms);
        b.flag   = 1'b1;
        send_beat(b);
        if (odds(70))
        begin
            t_cmd = clock_ms;
            send_beat(beat_of(REQ_COMMAND, clock_ms));
        end
        clock_ms = advance(clock_ms);
        t_motion = clock_ms;
        b        = beat_of(REQ_DEMAND, clock_ms);
        b.flag   = 1'b1;
        send_beat(b);
        n = $urandom_range(4, 24);
        repeat (n)
        begin
            r = $urandom_range(0, 19);
            if (r < 4)
            begin
                clock_ms = advance(clock_ms);
                t_cmd    = clock_ms;
                send_beat(beat_of(REQ_COMMAND, clock_ms));
            end
            else if (r < 7)
            begin
                clock_ms = advance(clock_ms);
                t_hall   = clock_ms;
                send_beat(beat_of(REQ_HALL, clock_ms));
            end
            else if (r < 15)
            begin
                case ($urandom_range(0, 9))
                    0:       b = beat_of(REQ_EVALUATE, at_edge(t_cmd, cur.link_timeout_ms));
                    1:       b = beat_of(REQ_EVALUATE,
                                         at_edge(t_motion, cur.startup_timeout_ms));
                    2:       b = beat_of(REQ_EVALUATE, at_edge(t_hall, cur.stall_timeout_ms));
                    default:
                    begin
                        clock_ms = advance(clock_ms);
                        b        = beat_of(REQ_EVALUATE, clock_ms);
                    end
                endcase
                b.adc_sample        = near_base();
                b.shutdown_pin_high = odds(95);
                b.hall_ok           = odds(95);
                b.adc_ok            = odds(95);
                send_beat(b);
            end
            else if (r == 15)
            begin
                b            = beat_of(REQ_LATCH, clock_ms);
                b.fault_mask = 9'($urandom_range(0, 511));
                if (odds(50))
                    send_beat(b);
            end
            else if (r == 16)
            begin
                clock_ms = advance(clock_ms);
                b        = beat_of(REQ_DEMAND, clock_ms);
                b.flag   = odds(60);
                if (b.flag)
                    t_motion = clock_ms;
                else
                    t_off = clock_ms;
                send_beat(b);
            end
            else if (r == 17)
            begin
                b      = beat_of(REQ_SET_ENABLE, clock_ms);
                b.flag = odds(70);
                send_beat(b);
            end
            else if (r == 18)
            begin
                b            = beat_of(REQ_ADC_OFF, clock_ms);
                b.adc_sample = 16'($urandom_range(0, 65535));
                send_beat(b);
            end
            else
                noise_burst();
        end

        // shutdown: both, enable only (demand dropped with it) or demand only
        r        = $urandom_range(0, 3);
        clock_ms = advance(clock_ms);
        if (r != 2)
        begin
            t_off = clock_ms;
            send_beat(beat_of(REQ_DEMAND, clock_ms));
        end
        if (r != 3)
            send_beat(beat_of(REQ_SET_ENABLE, clock_ms));

        // clear attempts, often right at the safe-time boundary
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            if (odds(50))
                b = beat_of(REQ_CLEAR, at_edge(t_off, cur.clear_safe_ms));
            else
            begin
                clock_ms = advance(clock_ms);
                b        = beat_of(REQ_CLEAR, clock_ms);
            end
            b.adc_sample        = near_base();
            b.shutdown_pin_high = odds(85);
            b.hall_ok           = odds(85);
            b.adc_ok            = odds(85);
            send_beat(b);
        end
    endtask

    task automatic run_phase(int items);
        int start;
        start = sent;
        while (sent - start < items)
        begin
            if (odds(75))
                run_session();
            else
                noise_burst();
        end
    endtask

    initial
    begin
        mbss_cfg_t s;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = CFG_IS_MASTER;
        cfg_if.data   = '0;
        rst_n         = 1'b0;
        idle_on       = 1'b1;
        sent          = 0;
        settings_used = 0;
        cur           = DEFAULT_SETTINGS;
        clock_ms      = '0;
        t_cmd         = '0;
        t_hall        = '0;
        t_motion      = '0;
        t_off         = '0;
        base_guess    = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_settings(DEFAULT_SETTINGS);
        run_directed();

        // defaults in master role, all zero, all ones, then random settings
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    s           = DEFAULT_SETTINGS;
                    s.is_master = 1'b1;
                end
                1:       s = '0;
                2:       s = '1;
                default: s = random_settings();
            endcase
            apply_settings(s);
            // last stretch runs with no gaps on either side
            if (phase == 5)
                idle_on = 1'b0;
            clock_ms = odds(50) ? 32'hFFFF_FFFF - $urandom_range(0, 20000) : $urandom;
            run_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (8) @(posedge clk);

        $display("Summary: %0d result beats checked under %0d register settings,",
                 beats_checked, settings_used);
        $display("         %0d clears granted, %0d beats with the bridge allowed",
                 clears_seen, allowed_seen);
        if (outstanding != 0)
            $display("%0t ns: %0d expected results never arrived", $time, outstanding);
        if (errors == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/mbss_pkg.sv
sv/mbss_if.sv
sv/mbss_cfg_regs.sv
sv/mbss_cal.sv
sv/mbss_core.sv
sv/motor_bridge_safety_supervisor.sv
sv/mbss_checker.sv
tb/mbss_checker.sv
tb/motor_bridge_safety_supervisor_tb.sv
